@@ design/quaternion_julia_escape_iterate_assert.svh @@
// Assertion macros for the quaternion Julia escape block.
// They expect signals named clk and arst_n in the using scope.
`ifndef QUATERNION_JULIA_ESCAPE_ITERATE_ASSERT_SVH
`define QUATERNION_JULIA_ESCAPE_ITERATE_ASSERT_SVH
`ifndef SYNTHESIS
`define QJE_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define QJE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define QJE_ASSERT_NOW(lbl, pre, post)
`define QJE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ design/qje_pkg.sv @@
`default_nettype none
package qje_pkg;
	typedef logic signed [31:0] comp_t;
	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_t;
	typedef struct packed {
		quat_t q;
		logic  skip;
	} item_t;
	typedef struct packed {
		logic        vld;
		logic        over;
		logic [63:0] sq;
	} len_req_t;
	typedef enum logic [2:0] {
		REG_C_REAL = 3'd0,
		REG_C_I    = 3'd1,
		REG_C_J    = 3'd2,
		REG_C_K    = 3'd3,
		REG_RADIUS = 3'd4,
		REG_LIMIT  = 3'd5
	} reg_idx_t;
	localparam comp_t       RST_C_REAL = 32'sd5033165;
	localparam comp_t       RST_C_I    = 32'sd8388608;
	localparam comp_t       RST_C_J    = 32'sd6710886;
	localparam comp_t       RST_C_K    = 32'sd3355443;
	localparam logic [30:0] RST_RADIUS = 31'd67108864;
	localparam logic [7:0]  RST_LIMIT  = 8'd8;
endpackage
`default_nettype wire

@@ design/qje_fifo.sv @@
`default_nettype none
module qje_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/qje_front.sv @@
`default_nettype none
module qje_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  qje_pkg::quat_t  start,
	input  logic [7:0]      limit,
	output qje_pkg::item_t  item,
	output logic            item_vld,
	input  logic            item_pop
);
	import qje_pkg::*;

	item_t in_item;
	logic  q_empty;

	// tag points that skip the iteration loop entirely
	assign in_item.q    = start;
	assign in_item.skip = (limit == '0);
	assign item_vld     = !q_empty;

	qje_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(2)
	) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (in_item),
		.full  (full),
		.pop   (item_pop),
		.dout  (item),
		.empty (q_empty)
	);
endmodule
`default_nettype wire

@@ design/qje_iter.sv @@
`default_nettype none
module qje_iter #(
	parameter int FRACTION_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qje_pkg::item_t     item,
	input  logic               item_vld,
	output logic               item_pop,
	input  qje_pkg::quat_t     c,
	input  logic [7:0]         limit,
	input  logic [61:0]        r2,
	output qje_pkg::len_req_t  len,
	input  logic               len_rdy
);
	import qje_pkg::*;

	localparam int AW = ((64 - FRACTION_BITS + 3) > 34) ? (64 - FRACTION_BITS + 3) : 34;

	typedef enum logic [2:0] {IDLE, SQ, CHK, CR, UPD, DONE} state_t;
	typedef logic signed [AW-1:0] acc_t;

	state_t             state_q;
	quat_t              q_q;
	acc_t               acc0_q, acc1_q, acc2_q, acc3_q;
	logic [64:0]        s_q;
	logic [7:0]         it_q;
	logic [2:0]         cnt_q;
	logic               skip_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] prod_w;
	logic [1:0]         sel;
	comp_t              sel_val;
	comp_t              op_b;
	acc_t               flr;
	logic               esc;

	function automatic comp_t sat(input acc_t v);
		if (&v[AW-1:31] || ~|v[AW-1:31]) begin
			return v[31:0];
		end
		return {v[AW-1], {31{~v[AW-1]}}};
	endfunction

	always_comb begin
		sel = (state_q == CR) ? cnt_q[1:0] + 2'd1 : cnt_q[1:0];
		case (sel)
			2'd0:    sel_val = q_q.x;
			2'd1:    sel_val = q_q.y;
			2'd2:    sel_val = q_q.z;
			default: sel_val = q_q.w;
		endcase
		op_b = (state_q == SQ) ? sel_val : q_q.x;
	end

	assign prod_w   = sel_val * op_b;
	assign flr      = AW'(prod_s1 >>> FRACTION_BITS);
	assign esc      = (it_q != '0) && (s_q[64] || (s_q[63:0] >= {2'b00, r2}));
	assign item_pop = (state_q == IDLE) && item_vld;
	assign len.vld  = (state_q == DONE);
	assign len.over = s_q[64];
	assign len.sq   = s_q[63:0];

	always_ff @(posedge clk) begin
		prod_s1 <= prod_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			q_q     <= '0;
			acc0_q  <= '0;
			acc1_q  <= '0;
			acc2_q  <= '0;
			acc3_q  <= '0;
			s_q     <= '0;
			it_q    <= '0;
			cnt_q   <= '0;
			skip_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (item_vld) begin
						q_q     <= item.q;
						skip_q  <= item.skip;
						it_q    <= '0;
						cnt_q   <= '0;
						s_q     <= '0;
						acc0_q  <= '0;
						state_q <= SQ;
					end
				end
				SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q != '0) begin
						s_q <= s_q + {1'b0, prod_s1};
						if (cnt_q == 3'd1) begin
							acc0_q <= acc0_q + flr;
						end else begin
							acc0_q <= acc0_q - flr;
						end
					end
					if (cnt_q == 3'd4) begin
						state_q <= CHK;
					end
				end
				CHK: begin
					cnt_q <= '0;
					if (esc || skip_q || (it_q == limit)) begin
						state_q <= DONE;
					end else begin
						state_q <= CR;
					end
				end
				CR: begin
					cnt_q <= cnt_q + 3'd1;
					case (cnt_q)
						3'd1:    acc1_q <= flr <<< 1;
						3'd2:    acc2_q <= flr <<< 1;
						3'd3:    acc3_q <= flr <<< 1;
						default: ;
					endcase
					if (cnt_q == 3'd3) begin
						state_q <= UPD;
					end
				end
				UPD: begin
					q_q.x   <= sat(acc0_q + AW'(c.x));
					q_q.y   <= sat(acc1_q + AW'(c.y));
					q_q.z   <= sat(acc2_q + AW'(c.z));
					q_q.w   <= sat(acc3_q + AW'(c.w));
					it_q    <= it_q + 8'd1;
					cnt_q   <= '0;
					s_q     <= '0;
					acc0_q  <= '0;
					state_q <= SQ;
				end
				DONE: begin
					if (len_rdy) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/qje_sqrt.sv @@
`default_nettype none
module qje_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  qje_pkg::len_req_t len,
	output logic              len_rdy,
	output logic              res_vld,
	output logic [31:0]       res,
	input  logic              res_rdy
);
	import qje_pkg::*;

	typedef enum logic [1:0] {IDLE, RUN, OUT} state_t;

	state_t      state_q;
	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  n_q;
	logic        over_q;
	logic [34:0] rem_n;
	logic [34:0] trial;

	assign rem_n   = {rem_q[32:0], rad_q[63:62]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign len_rdy = (state_q == IDLE);
	assign res_vld = (state_q == OUT);
	assign res     = over_q ? '1 : root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			n_q     <= '0;
			over_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (len.vld) begin
						rad_q   <= len.sq;
						over_q  <= len.over;
						rem_q   <= '0;
						root_q  <= '0;
						n_q     <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					rad_q <= {rad_q[61:0], 2'b00};
					if (rem_n >= trial) begin
						rem_q  <= rem_n - trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= rem_n;
						root_q <= {root_q[30:0], 1'b0};
					end
					n_q <= n_q + 5'd1;
					if (n_q == 5'd31) begin
						state_q <= OUT;
					end
				end
				OUT: begin
					if (res_rdy) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/quaternion_julia_escape_iterate.sv @@
`default_nettype none
// Quaternion Julia escape-time unit. Each request is a start quaternion in signed
// fixed point; the block iterates Z = Z*Z + C with saturation, at most iteration_limit
// times, stopping early once |Z|^2 reaches escape_radius^2, and returns floor(|Z|) as
// unsigned fixed point. One shared 32x32 multiplier does the iteration work: 7 products
// per iteration, plus those for the start length, then a bit-serial square root that
// overlaps the next point's iterations. Sustained rate is set by the slower of the
// iteration loop and the square root. Two-entry queues sit on input and result sides.
// Write configuration only while the block is idle.
module quaternion_julia_escape_iterate #(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] start_real,
	input  logic [31:0] start_i,
	input  logic [31:0] start_j,
	input  logic [31:0] start_k,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] final_magnitude,
	input  logic        write_en,
	input  logic [2:0]  write_index,
	input  logic [31:0] write_data
);
	import qje_pkg::*;

	quat_t       c_q;
	logic [30:0] radius_q;
	logic [7:0]  limit_q;
	logic [61:0] r2_q;
	quat_t       start;
	item_t       item;
	logic        item_vld;
	logic        item_pop;
	len_req_t    len;
	logic        len_rdy;
	logic        res_vld;
	logic [31:0] res;
	logic        out_full;

	assign start.x = start_real;
	assign start.y = start_i;
	assign start.z = start_j;
	assign start.w = start_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q.x    <= RST_C_REAL;
			c_q.y    <= RST_C_I;
			c_q.z    <= RST_C_J;
			c_q.w    <= RST_C_K;
			radius_q <= RST_RADIUS;
			limit_q  <= RST_LIMIT;
		end else if (write_en) begin
			case (reg_idx_t'(write_index))
				REG_C_REAL: c_q.x    <= write_data;
				REG_C_I:    c_q.y    <= write_data;
				REG_C_J:    c_q.z    <= write_data;
				REG_C_K:    c_q.w    <= write_data;
				REG_RADIUS: radius_q <= write_data[30:0];
				REG_LIMIT:  limit_q  <= write_data[7:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= radius_q * radius_q;
	end

	qje_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.start   (start),
		.limit   (limit_q),
		.item    (item),
		.item_vld(item_vld),
		.item_pop(item_pop)
	);

	qje_iter #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.item_vld(item_vld),
		.item_pop(item_pop),
		.c       (c_q),
		.limit   (limit_q),
		.r2      (r2_q),
		.len     (len),
		.len_rdy (len_rdy)
	);

	qje_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.len    (len),
		.len_rdy(len_rdy),
		.res_vld(res_vld),
		.res    (res),
		.res_rdy(!out_full)
	);

	qje_fifo #(
		.WIDTH(32),
		.DEPTH(2)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_vld),
		.din   (res),
		.full  (out_full),
		.pop   (pop),
		.dout  (final_magnitude),
		.empty (empty)
	);

`include "quaternion_julia_escape_iterate_assert.svh"
	`QJE_ASSERT_NEXT(a_sqrt_take, len.vld && len_rdy, !len_rdy)
	`QJE_ASSERT_NEXT(a_len_hold, len.vld && !len_rdy, len.vld && $stable(len.sq))
	`QJE_ASSERT_NEXT(a_res_hold, res_vld && out_full, res_vld && $stable(res))
	`QJE_ASSERT_NOW(a_no_pop_idle, item_pop, item_vld)
endmodule
`default_nettype wire
